// ----- hw/rtl/swm_pkg.sv -----
`default_nettype none
package swm_pkg;

	// Sizing of the candidate chain
	localparam int unsigned MAX_WINDOW = 64;
	localparam int unsigned POS_W      = $clog2(2 * MAX_WINDOW);
	localparam int unsigned WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned CFG_W      = 7;

	typedef logic [POS_W-1:0]           pos_t;
	typedef logic [WIN_W-1:0]           win_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Input transaction
	typedef struct packed {
		sample_t sample;
		logic    first_of_array;
		logic    last_of_array;
	} swm_in_t;

	// Result transaction
	typedef struct packed {
		sample_t window_max;
		logic    last_result;
	} swm_out_t;

	// One queued candidate
	typedef struct packed {
		logic    valid;
		sample_t value;
		pos_t    pos;
	} cell_data_t;

	// Values broadcast to every cell for the sample being taken
	typedef struct packed {
		sample_t sample;
		pos_t    pos;
		win_t    win;
		logic    first;
	} cell_bcast_t;

	// Chain control shared by all cells
	typedef struct packed {
		logic take;
		logic shift;
		logic bubble;
	} queue_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sliding_window_maximum.sv -----
// Running maximum over the last window_size samples (1 to 64; 0 acts as 1,
// larger values as 64), to be written through the configuration channel while
// idle; the block does not enforce this. Each accepted sample yields one result
// once the window of the current array has filled; an array shorter than the
// window yields none, and first_of_array starts a new array. A taken sample's
// result is registered from the head cell once the chain is not realigning and
// the output register is free, so a steady stream runs at one sample per cycle
// without back-pressure. After a mid-array window shrink, candidates that expire
// together leave empty cells at the chain head; the chain moves one cell per
// cycle, and the result and the next sample wait until the head is occupied.
`default_nettype none
module sliding_window_maximum (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_ready,
	input  swm_pkg::swm_in_t     item,
	output logic                 result_valid,
	input  wire                  result_ready,
	output swm_pkg::swm_out_t    result,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [swm_pkg::CFG_W-1:0] cfg_data
);
	import swm_pkg::*;

	localparam int unsigned PX_W = POS_W + 1;

	logic [CFG_W-1:0] ws_q;
	pos_t             pos_q;
	logic             filled_q;
	logic             pend_q;
	logic             last_q;
	logic             result_valid_q;
	swm_out_t         result_q;

	win_t        win;
	pos_t        pos_eff;
	logic        filled_eff;
	logic        filled_nxt;
	logic        take;
	logic        out_free;
	logic        out_load;
	logic        busy;
	cell_data_t  head;
	cell_bcast_t bcast;

	// Clamp the configured window
	always_comb begin
		if (ws_q == '0) begin
			win = WIN_W'(1);
		end else if (32'(ws_q) > 32'(MAX_WINDOW)) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = WIN_W'(ws_q);
		end
	end

	// Handshake and position bookkeeping
	always_comb begin
		out_free   = ~result_valid_q | result_ready;
		out_load   = pend_q & ~busy & out_free;
		item_ready = ~busy & (~pend_q | out_free);
		take       = item_valid & item_ready;
		pos_eff    = item.first_of_array ? '0 : pos_q;
		filled_eff = item.first_of_array ? 1'b0 : filled_q;
		filled_nxt = filled_eff | ((PX_W'(pos_eff) + PX_W'(1)) >= PX_W'(win));
		bcast      = '{sample: item.sample, pos: pos_eff, win: win,
		               first: item.first_of_array};
	end

	swm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.bcast  (bcast),
		.head   (head),
		.busy   (busy)
	);

	// Window size register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			ws_q <= cfg_data;
		end
	end

	// Advance position and fill state, hold a pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
			pend_q   <= 1'b0;
		end else if (take) begin
			pos_q    <= pos_eff + POS_W'(1);
			filled_q <= filled_nxt;
			pend_q   <= filled_nxt;
		end else if (out_load) begin
			pend_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_q <= item.last_of_array;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= '{window_max: head.value, last_result: last_q};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Never take a sample while the chain is realigning
	a_take_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !busy)
		else $error("sample taken during chain realignment");

	// The chain is never empty after a sample is taken
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (head.valid || busy))
		else $error("candidate chain empty after a sample");

	// A result is only loaded from an occupied head cell
	a_load_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> head.valid)
		else $error("result loaded from empty head cell");

	// A pending result is never overwritten by a new sample
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pend_q) |-> out_load)
		else $error("pending result lost");

endmodule
`default_nettype wire

// ----- hw/rtl/swm_cell.sv -----
`default_nettype none
module swm_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  swm_pkg::cell_bcast_t bcast,
	input  swm_pkg::queue_ctl_t  ctl,
	input  wire                  keep_l,
	input  wire                  keep_r,
	input  swm_pkg::cell_data_t  entry_r,
	input  wire                  seed,
	output swm_pkg::cell_data_t  entry,
	output logic                 keep
);
	import swm_pkg::*;

	logic       valid_q;
	sample_t    value_q;
	pos_t       pos_q;
	cell_data_t nxt;
	cell_data_t fresh;
	pos_t       age;

	assign entry = '{valid: valid_q, value: value_q, pos: pos_q};

	// Survive the head expiry and the tail pop for this sample
	always_comb begin
		age  = bcast.pos - pos_q;
		keep = valid_q & ~bcast.first & (age < bcast.win) &
		       (value_q > bcast.sample);
	end

	// Choose the next content: hold, take the neighbour's, take the new sample or drop
	always_comb begin
		fresh = '{valid: 1'b1, value: bcast.sample, pos: bcast.pos};
		nxt   = entry;
		if (ctl.bubble) begin
			nxt = entry_r;
		end else if (ctl.take) begin
			if (ctl.shift) begin
				if (keep_r) begin
					nxt = entry_r;
				end else if ((keep & ~keep_r) | seed) begin
					nxt = fresh;
				end else begin
					nxt.valid = 1'b0;
				end
			end else begin
				if (keep) begin
					nxt = entry;
				end else if (keep_l) begin
					nxt = fresh;
				end else begin
					nxt.valid = 1'b0;
				end
			end
		end
	end

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	// Candidate payload
	always_ff @(posedge clk) begin
		value_q <= nxt.value;
		pos_q   <= nxt.pos;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/swm_queue.sv -----
`default_nettype none
module swm_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  take,
	input  swm_pkg::cell_bcast_t bcast,
	output swm_pkg::cell_data_t  head,
	output logic                 busy
);
	import swm_pkg::*;

	cell_data_t             ent [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]  keep;
	logic [MAX_WINDOW-1:0]  vld;
	queue_ctl_t             ctl;
	logic                   kept_none;

	// Realign when the head cell is empty but candidates remain further down
	always_comb begin
		kept_none  = ~(|keep);
		busy       = ~ent[0].valid & (|vld);
		ctl.take   = take;
		ctl.shift  = ~keep[0];
		ctl.bubble = busy & ~take;
	end

	// Chain of candidate cells, head at cell zero
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic       kl;
		logic       kr;
		cell_data_t er;
		logic       sd;

		if (i == 0) begin : g_first
			assign kl = 1'b0;
			assign sd = kept_none;
		end else begin : g_mid
			assign kl = keep[i-1];
			assign sd = 1'b0;
		end

		if (i == MAX_WINDOW - 1) begin : g_last
			assign kr = 1'b0;
			assign er = '0;
		end else begin : g_inner
			assign kr = keep[i+1];
			assign er = ent[i+1];
		end

		swm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bcast   (bcast),
			.ctl     (ctl),
			.keep_l  (kl),
			.keep_r  (kr),
			.entry_r (er),
			.seed    (sd),
			.entry   (ent[i]),
			.keep    (keep[i])
		);

		assign vld[i] = ent[i].valid;
	end

	assign head = ent[0];

endmodule
`default_nettype wire

// ----- verif/sliding_window_maximum_tb.sv -----
`timescale 1ns / 100ps
module sliding_window_maximum_tb;
	import swm_pkg::*;

	localparam int unsigned DRAIN_CYCLES   = 72;
	localparam int unsigned HOLD_CYCLES    = 200;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PHASE_ITEMS    = 300;
	localparam int unsigned EXP_DEPTH      = 16;
	localparam int unsigned ROW_DEPTH      = 32;
	localparam sample_t     S_MIN          = 32'h8000_0000;
	localparam sample_t     S_MAX          = 32'h7FFF_FFFF;

	typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_e;
	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e          kind;
		logic [CFG_W-1:0]   win;
		swm_in_t            tr;
		bit                 typed;
		swm_out_t           want;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	swm_in_t          item;
	logic             result_valid;
	logic             result_ready;
	swm_out_t         result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// Window state mirrored for prediction
	logic [CFG_W-1:0] win_reg;
	sample_t          cand_val [MAX_WINDOW];
	pos_t             cand_pos [MAX_WINDOW];
	int unsigned      cand_cnt;
	pos_t             next_pos;
	bit               filled;

	// Expected results, oldest at exp_rd
	swm_out_t         exp_fifo [EXP_DEPTH];
	int unsigned      exp_wr;
	int unsigned      exp_rd;
	stim_row_t        stim_rows [ROW_DEPTH];
	int unsigned      n_rows;
	int unsigned      mismatches;
	int unsigned      sent_in_phase;
	idle_mode_e       idle_mode;
	bit               stall_request;
	int unsigned      hold_left;
	int unsigned      quiet_cycles;

	sliding_window_maximum i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the candidate queue by one sample; return 1 when a maximum is due
	function automatic bit slide_window(input swm_in_t tr, output swm_out_t res);
		int unsigned w;
		pos_t        pos;
		w = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
		if (tr.first_of_array) begin
			cand_cnt = 0;
			next_pos = '0;
			filled   = 1'b0;
		end
		pos = next_pos;
		// drop heads that have aged out (positions wrap modulo 2*MAX_WINDOW)
		while (cand_cnt > 0 && pos_t'(pos - cand_pos[0]) >= w) begin
			for (int k = 1; k < cand_cnt; k++) begin
				cand_val[k-1] = cand_val[k];
				cand_pos[k-1] = cand_pos[k];
			end
			cand_cnt--;
		end
		// drop tail candidates dominated by the new sample
		while (cand_cnt > 0 && cand_val[cand_cnt-1] <= tr.sample)
			cand_cnt--;
		if (cand_cnt < MAX_WINDOW) begin
			cand_val[cand_cnt] = tr.sample;
			cand_pos[cand_cnt] = pos;
			cand_cnt++;
		end
		if (pos + 1 >= w)
			filled = 1'b1;
		next_pos = pos + 1'b1;
		res.window_max  = cand_val[0];
		res.last_result = tr.last_of_array;
		return filled;
	endfunction

	function automatic void add_row(input row_kind_e kind, input logic [CFG_W-1:0] win,
			input sample_t s, input bit first, input bit last,
			input bit typed, input sample_t want_max, input bit want_last);
		stim_row_t row;
		row.kind                = kind;
		row.win                 = win;
		row.tr.sample           = s;
		row.tr.first_of_array   = first;
		row.tr.last_of_array    = last;
		row.typed               = typed;
		row.want.window_max     = want_max;
		row.want.last_result    = want_last;
		stim_rows[n_rows]       = row;
		n_rows++;
	endfunction

	// Queue one expected result transaction
	function automatic void expect_result(input swm_out_t r);
		exp_fifo[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endfunction

	// Compare one result transaction against the oldest expectation
	function automatic void check_result(input swm_out_t got);
		swm_out_t want;
		if (exp_wr == exp_rd) begin
			mismatches++;
			$display("%0t: result with nothing expected: window_max %0d last_result %0b",
				$time, got.window_max, got.last_result);
		end else begin
			want = exp_fifo[exp_rd % EXP_DEPTH];
			exp_rd++;
			if (got.window_max !== want.window_max) begin
				mismatches++;
				$display("%0t: window_max expected %0d got %0d",
					$time, want.window_max, got.window_max);
			end
			if (got.last_result !== want.last_result) begin
				mismatches++;
				$display("%0t: last_result expected %0b got %0b",
					$time, want.last_result, got.last_result);
			end
		end
	endfunction

	// Hold the item channel idle for a random number of cycles
	task automatic sender_gap();
		int unsigned pct;
		pct = (idle_mode == IDLE_RX_HEAVY) ? 11 : ((idle_mode == IDLE_TX_HEAVY) ? 84 : 0);
		if ($urandom_range(0, 99) < pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < pct);
		end
	endtask

	// Offer one sample and record its expected maximum once accepted
	task automatic send_item(input swm_in_t tr, input bit typed, input swm_out_t want);
		swm_out_t res;
		item       <= tr;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sent_in_phase++;
		if (slide_window(tr, res))
			expect_result(typed ? want : res);
	endtask

	// Let the block drain completely, including a shrink stall on the last sample
	task automatic settle();
		item_valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] w);
		settle();
		cfg_data  <= w;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_reg = w;
	endtask

	// One array of samples with a random shape; fresh sets the start flag
	task automatic send_array(input int unsigned span, input bit fresh);
		int unsigned len;
		int unsigned shape;
		int unsigned n;
		sample_t     ramp;
		swm_in_t     tr;
		if (span > 1 && $urandom_range(0, 99) < 15)
			len = $urandom_range(1, span - 1);
		else
			len = span + $urandom_range(0, 8);
		shape = $urandom_range(0, 4);
		ramp  = sample_t'($urandom_range(0, 32'h3FFF_FFFF)) - sample_t'(32'h2000_0000);
		for (n = 0; n < len; n++) begin
			case (shape)
				0: tr.sample = $urandom;
				1: tr.sample = sample_t'($urandom_range(0, 8)) - 4;
				2: begin
					ramp      = ramp - sample_t'($urandom_range(1, 3));
					tr.sample = ramp;
				end
				3: begin
					ramp      = ramp + sample_t'($urandom_range(1, 3));
					tr.sample = ramp;
				end
				default: begin
					case ($urandom_range(0, 4))
						0:       tr.sample = S_MIN;
						1:       tr.sample = S_MAX;
						2:       tr.sample = '0;
						3:       tr.sample = '1;
						default: tr.sample = $urandom;
					endcase
				end
			endcase
			tr.first_of_array = (n == 0) ? fresh : ($urandom_range(0, 99) < 2);
			tr.last_of_array  = (n == len - 1) ? ($urandom_range(0, 9) != 0)
				: ($urandom_range(0, 99) < 3);
			sender_gap();
			send_item(tr, 1'b0, '0);
		end
	endtask

	// Consume results, with random back-pressure and one long hold-off
	initial begin
		result_ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				check_result(result);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_left     = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (idle_mode == IDLE_RX_HEAVY) begin
				result_ready <= ($urandom_range(0, 99) >= 84);
			end else if (idle_mode == IDLE_TX_HEAVY) begin
				result_ready <= ($urandom_range(0, 99) >= 11);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// End the run when no transaction has moved for too long
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL sliding_window_maximum");
		$finish;
	end

	initial begin
		int               phase;
		int unsigned      arrays;
		int unsigned      a;
		int unsigned      eff;
		bit               first_seg;
		logic [CFG_W-1:0] win;

		arst_n        <= 1'b0;
		item_valid    <= 1'b0;
		item          <= '0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		mismatches    = 0;
		sent_in_phase = 0;
		stall_request = 1'b0;
		idle_mode     = IDLE_RX_HEAVY;
		win_reg       = 7'd1;
		cand_cnt      = 0;
		next_pos      = '0;
		filled        = 1'b0;
		exp_wr        = 0;
		exp_rd        = 0;
		n_rows        = 0;

		// Directed rows: reset window, extremes, zero and saturated sizes,
		// short arrays, ties, shrinking and growing the window mid-array
		add_row(ROW_ITEM, 0, S_MIN, 1, 0, 1, S_MIN, 0);
		add_row(ROW_ITEM, 0, S_MAX, 0, 1, 1, S_MAX, 1);
		add_row(ROW_ITEM, 0, '1, 0, 1, 1, '1, 1);
		add_row(ROW_CFG, 7'd0, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 32'h5555_5555, 1, 1, 1, 32'h5555_5555, 1);
		add_row(ROW_ITEM, 0, 32'hAAAA_AAAA, 0, 0, 1, 32'hAAAA_AAAA, 0);
		add_row(ROW_CFG, 7'd3, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 10, 1, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 20, 0, 1, 0, 0, 0);
		add_row(ROW_ITEM, 0, 7, 1, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 7, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 7, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, -1, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 100, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 50, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 40, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 30, 0, 1, 0, 0, 0);
		add_row(ROW_CFG, 7'd4, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 9, 1, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 8, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 7, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 6, 0, 0, 0, 0, 0);
		add_row(ROW_CFG, 7'd1, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 5, 0, 0, 1, 5, 0);
		add_row(ROW_ITEM, 0, 4, 0, 0, 1, 4, 0);
		add_row(ROW_CFG, 7'd3, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 2, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, 1, 0, 1, 0, 0, 0);
		add_row(ROW_CFG, 7'd127, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ITEM, 0, S_MAX, 1, 1, 0, 0, 0);

		// Reset once
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < n_rows; i++) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				write_window(stim_rows[i].win);
			end else begin
				sender_gap();
				send_item(stim_rows[i].tr, stim_rows[i].typed, stim_rows[i].want);
			end
		end

		// Random arrays under each idling mix, window rewritten between segments
		for (phase = 0; phase < 3; phase++) begin
			idle_mode     = idle_mode_e'(phase);
			sent_in_phase = 0;
			first_seg     = 1'b1;
			while (sent_in_phase < PHASE_ITEMS) begin
				case ($urandom_range(0, 19))
					0:       win = 7'd0;
					1:       win = 7'd64;
					2:       win = CFG_W'($urandom_range(65, 127));
					3, 4, 5: win = 7'd1;
					default: win = CFG_W'($urandom_range(2, 12));
				endcase
				if (idle_mode == IDLE_NONE && first_seg)
					win = 7'd1;
				write_window(win);
				eff = (win == 0) ? 1 : ((win > MAX_WINDOW) ? MAX_WINDOW : win);
				// fill the block while the result side is held off
				if (idle_mode == IDLE_NONE && first_seg)
					stall_request = 1'b1;
				arrays = $urandom_range(1, 4);
				for (a = 0; a < arrays; a++)
					send_array(eff, (a != 0) || ($urandom_range(0, 3) != 0));
				first_seg = 1'b0;
			end
		end

		settle();
		if (mismatches == 0 && exp_wr == exp_rd)
			$display("PASS sliding_window_maximum");
		else
			$display("FAIL sliding_window_maximum");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_queue.sv
hw/rtl/sliding_window_maximum.sv
verif/sliding_window_maximum_tb.sv
